// ----- rtl/indi_rate_controller_defines.svh -----
// ---------------------------------------------------------------------------
// INDI rate controller assertion macros
// Shared property forms for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef INDI_RATE_CONTROLLER_DEFINES_SVH
`define INDI_RATE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define IRA_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset
`define IRA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ira_pkg.sv -----
// ---------------------------------------------------------------------------
// INDI rate controller package
// Fixed-point widths, item types, codes and saturating helpers.
// ---------------------------------------------------------------------------
package ira_pkg;

  localparam int DW = 32;           // data width
  localparam int FB = 16;           // fraction bits
  localparam int NW = DW + FB;      // scaled dividend width
  localparam int CFG_IDX_W = 3;

  typedef logic signed [DW-1:0] fx_t;
  typedef logic signed [DW:0]   fxw_t;   // one guard bit

  localparam fx_t FX_MAX  = fx_t'({1'b0, {(DW-1){1'b1}}});
  localparam fx_t FX_MIN  = fx_t'({1'b1, {(DW-1){1'b0}}});
  localparam fx_t FX_ONE  = fx_t'(1) <<< FB;
  localparam fx_t FX_HALF = fx_t'(1) <<< (FB - 1);

  // Request codes
  localparam logic [1:0] REQ_UPDATE = 2'd0;
  localparam logic [1:0] REQ_SET    = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EFF  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAU  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LO   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HI   = 3'd4;

  typedef struct packed {
    logic [1:0] req_type;
    fx_t        rate_setpoint;
    fx_t        rate_measured;
    fx_t        time_step;
    fx_t        applied_command;
  } in_item_t;

  typedef struct packed {
    fx_t  command;
    logic seeded;
  } out_item_t;

  // Clip a wide signed value to the data range
  function automatic fx_t fx_sat(input logic signed [2*DW:0] x);
    logic signed [2*DW:0] hi;
    logic signed [2*DW:0] lo;
    hi = {{(DW+1){1'b0}}, FX_MAX};
    lo = {{(DW+1){1'b1}}, FX_MIN};
    if (x > hi) return FX_MAX;
    if (x < lo) return FX_MIN;
    return x[DW-1:0];
  endfunction

  function automatic fx_t fx_add(input fx_t a, input fx_t b);
    logic signed [2*DW:0] s;
    s = {{(DW+1){a[DW-1]}}, a} + {{(DW+1){b[DW-1]}}, b};
    return fx_sat(s);
  endfunction

  function automatic fx_t fx_sub(input fx_t a, input fx_t b);
    logic signed [2*DW:0] s;
    s = {{(DW+1){a[DW-1]}}, a} - {{(DW+1){b[DW-1]}}, b};
    return fx_sat(s);
  endfunction

  // Drop fraction bits of a product, round half up, clip
  function automatic fx_t fx_rnd(input logic signed [2*DW-1:0] p);
    logic signed [2*DW:0] t;
    t = $signed({p[2*DW-1], p}) + $signed({{(2*DW+1-FB){1'b0}}, {1'b1, {(FB-1){1'b0}}}});
    t = t >>> FB;
    return fx_sat(t);
  endfunction

endpackage

// ----- rtl/ira_div.sv -----
// ---------------------------------------------------------------------------
// INDI rate controller divider
// Shared restoring divider, one quotient bit per cycle, Q-format scaled,
// rounded half away from zero and clipped to the data range.
// ---------------------------------------------------------------------------
module ira_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  ira_pkg::fx_t  num_i,
  input  ira_pkg::fxw_t den_i,
  output logic          done_o,
  output ira_pkg::fx_t  quot_o
);
  import ira_pkg::*;

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] un_q;
  logic [NW-1:0] quo_q;
  logic [DW:0]   ud_q;
  logic [DW:0]   rem_q;
  logic          neg_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;

  logic [DW-1:0] ua;
  logic [DW:0]   ud;
  logic [NW-1:0] un;
  logic [DW+1:0] rem_sh;
  logic          qbit;
  logic [DW:0]   rem_d;

  // Operand magnitudes and rounding bias
  always_comb begin
    ua = num_i[DW-1] ? DW'(-num_i) : DW'(num_i);
    ud = den_i[DW] ? (DW+1)'(-den_i) : (DW+1)'(den_i);
    un = (NW'(ua) << FB) + NW'(ud >> 1);
  end

  // One restoring step
  always_comb begin
    rem_sh = {rem_q, un_q[NW-1]};
    qbit   = rem_sh >= {1'b0, ud_q};
    rem_d  = qbit ? (DW+1)'(rem_sh - {1'b0, ud_q}) : rem_sh[DW:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      un_q  <= un;
      ud_q  <= ud;
      rem_q <= '0;
      quo_q <= '0;
      neg_q <= num_i[DW-1] ^ den_i[DW];
    end else if (busy_q) begin
      un_q  <= un_q << 1;
      rem_q <= rem_d;
      quo_q <= {quo_q[NW-2:0], qbit};
    end
  end

  // Clip and apply sign
  always_comb begin
    if (quo_q > NW'(FX_MAX)) begin
      quot_o = neg_q ? FX_MIN : FX_MAX;
    end else begin
      quot_o = neg_q ? fx_t'(-quo_q[DW-1:0]) : fx_t'(quo_q[DW-1:0]);
    end
  end

  assign done_o = done_q;

endmodule

// ----- rtl/indi_rate_controller.sv -----
// ---------------------------------------------------------------------------
// INDI rate controller
// Single-axis incremental dynamic inversion rate loop, Q16.16, run by a
// sequencer over one shared multiplier and one shared divider.
// ---------------------------------------------------------------------------
// Use: write registers on cfg_we_i/cfg_idx_i/cfg_wdata_i while idle. Send
// items on in_valid_i/in_ready_o; only an update item yields a result item
// on out_valid_o/out_ready_i. A clear item is handled in the idle state and
// a set-applied item runs one multiply. A seeding update goes straight to
// the emit state. A full update makes three divider passes (launch, 48
// quotient bits, done) and 4 multiplies (load, wait, use); the next item is
// taken once its result is loaded into the output register. The divider
// sets the rate. With filter_time_constant <= 0 the alpha division is
// skipped. in_ready_o is high only while idle.
// Reset: registers take their defaults, filter state is cleared and the
// next update seeds. A stalled receiver holds the result item in the output
// register; a following update waits before emitting until it is taken.
// ---------------------------------------------------------------------------
module indi_rate_controller (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ira_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  ira_pkg::fx_t                        cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  ira_pkg::in_item_t                   in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output ira_pkg::out_item_t                  out_item_o
);
  import ira_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ALPHA, ST_G_LOAD, ST_G_WAIT, ST_G_USE, ST_ACC,
    ST_AF_LOAD, ST_AF_WAIT, ST_AF_USE, ST_DES_LOAD, ST_DES_WAIT, ST_DES_USE,
    ST_U, ST_CF_LOAD, ST_CF_WAIT, ST_CF_USE, ST_SET_WAIT, ST_SET_USE, ST_EMIT
  } state_e;

  state_e    state_q;
  fx_t       eff_q, gain_q, tau_q, lo_q, hi_q;
  fx_t       gyro_q, accel_f_q, cmd_f_q;
  logic      started_q;
  in_item_t  item_q;
  fx_t       alpha_q, prev_q, accel_q, u_q;
  fx_t       mul_a_q, mul_b_q;
  logic signed [2*DW-1:0] prod_q;
  logic      div_start_q;
  logic      div_start_d;
  fx_t       div_num_q;
  fxw_t      div_den_q;
  logic      out_valid_q;
  out_item_t out_item_q, res_q;

  logic  div_done;
  fx_t   div_quot;
  logic  tau_pos;
  fx_t   prod_rnd;
  fx_t   gyro_next;
  fx_t   u_raw, u_clip, lim_lo, lim_hi;
  fx_t   eff_use;

  ira_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start_q),
    .num_i  (div_num_q),
    .den_i  (div_den_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Shared multiplier, registered
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a_q * mul_b_q;
  end

  // Operand conditioning and clamp
  always_comb begin
    tau_pos   = tau_q > 0;
    prod_rnd  = fx_rnd(prod_q);
    gyro_next = fx_add(gyro_q, prod_rnd);
    eff_use   = (eff_q == '0) ? fx_t'(1) : eff_q;
    lim_lo    = (lo_q > hi_q) ? hi_q : lo_q;
    lim_hi    = (lo_q > hi_q) ? lo_q : hi_q;
    u_raw     = fx_add(cmd_f_q, div_quot);
    u_clip    = u_raw;
    if (u_clip < lim_lo) u_clip = lim_lo;
    if (u_clip > lim_hi) u_clip = lim_hi;
  end

  // Launch the divider for alpha, the derivative and the command step
  assign div_start_d = (state_q == ST_IDLE && in_valid_i &&
                        in_item_i.req_type == REQ_UPDATE && started_q &&
                        in_item_i.time_step > 0 && tau_pos) ||
                       state_q == ST_G_USE || state_q == ST_DES_USE;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_q  <= FX_ONE;
      gain_q <= '0;
      tau_q  <= '0;
      lo_q   <= -FX_ONE;
      hi_q   <= FX_ONE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_EFF:  eff_q  <= cfg_wdata_i;
        CFG_GAIN: gain_q <= cfg_wdata_i;
        CFG_TAU:  tau_q  <= cfg_wdata_i;
        CFG_LO:   lo_q   <= cfg_wdata_i;
        CFG_HI:   hi_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequencer, filter state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      started_q   <= 1'b0;
      gyro_q      <= '0;
      accel_f_q   <= '0;
      cmd_f_q     <= '0;
      out_valid_q <= 1'b0;
      div_start_q <= 1'b0;
    end else begin
      div_start_q <= div_start_d;
      // Drop a taken result unless a new one is loaded this cycle
      if (out_valid_q && out_ready_i && state_q != ST_EMIT) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            item_q <= in_item_i;
            priority if (in_item_i.req_type == REQ_CLEAR) begin
              gyro_q    <= '0;
              accel_f_q <= '0;
              cmd_f_q   <= '0;
              started_q <= 1'b0;
            end else if (in_item_i.req_type == REQ_SET) begin
              mul_a_q <= tau_pos ? FX_HALF : FX_ONE;
              mul_b_q <= fx_sub(in_item_i.applied_command, cmd_f_q);
              state_q <= ST_SET_WAIT;
            end else if (in_item_i.req_type == REQ_UPDATE) begin
              if (!started_q || in_item_i.time_step <= 0) begin
                // Seed the rate filter
                gyro_q    <= in_item_i.rate_measured;
                accel_f_q <= '0;
                started_q <= 1'b1;
                res_q     <= '{command: '0, seeded: 1'b1};
                state_q   <= ST_EMIT;
              end else if (tau_pos) begin
                div_num_q   <= in_item_i.time_step;
                div_den_q   <= {in_item_i.time_step[DW-1], in_item_i.time_step}
                               + {1'b0, tau_q};
                state_q     <= ST_ALPHA;
              end else begin
                alpha_q <= FX_ONE;
                state_q <= ST_G_LOAD;
              end
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_ALPHA: begin
          if (div_done) begin
            alpha_q <= div_quot;
            state_q <= ST_G_LOAD;
          end
        end
        ST_G_LOAD: begin
          mul_a_q <= alpha_q;
          mul_b_q <= fx_sub(item_q.rate_measured, gyro_q);
          prev_q  <= gyro_q;
          state_q <= ST_G_WAIT;
        end
        ST_G_WAIT: state_q <= ST_G_USE;
        ST_G_USE: begin
          // Differentiate the filtered rate
          gyro_q      <= gyro_next;
          div_num_q   <= fx_sub(gyro_next, prev_q);
          div_den_q   <= {item_q.time_step[DW-1], item_q.time_step};
          state_q     <= ST_ACC;
        end
        ST_ACC: begin
          if (div_done) begin
            accel_q <= div_quot;
            state_q <= ST_AF_LOAD;
          end
        end
        ST_AF_LOAD: begin
          mul_a_q <= alpha_q;
          mul_b_q <= fx_sub(accel_q, accel_f_q);
          state_q <= ST_AF_WAIT;
        end
        ST_AF_WAIT: state_q <= ST_AF_USE;
        ST_AF_USE: begin
          accel_f_q <= fx_add(accel_f_q, prod_rnd);
          state_q   <= ST_DES_LOAD;
        end
        ST_DES_LOAD: begin
          mul_a_q <= gain_q;
          mul_b_q <= fx_sub(item_q.rate_setpoint, item_q.rate_measured);
          state_q <= ST_DES_WAIT;
        end
        ST_DES_WAIT: state_q <= ST_DES_USE;
        ST_DES_USE: begin
          // Acceleration gap over effectiveness
          div_num_q   <= fx_sub(prod_rnd, accel_f_q);
          div_den_q   <= {eff_use[DW-1], eff_use};
          state_q     <= ST_U;
        end
        ST_U: begin
          if (div_done) begin
            u_q     <= u_clip;
            state_q <= ST_CF_LOAD;
          end
        end
        ST_CF_LOAD: begin
          mul_a_q <= alpha_q;
          mul_b_q <= fx_sub(u_q, cmd_f_q);
          state_q <= ST_CF_WAIT;
        end
        ST_CF_WAIT: state_q <= ST_CF_USE;
        ST_CF_USE: begin
          cmd_f_q <= fx_add(cmd_f_q, prod_rnd);
          res_q   <= '{command: u_q, seeded: 1'b0};
          state_q <= ST_EMIT;
        end
        ST_SET_WAIT: state_q <= ST_SET_USE;
        ST_SET_USE: begin
          cmd_f_q <= fx_add(cmd_f_q, prod_rnd);
          state_q <= ST_IDLE;
        end
        ST_EMIT: begin
          // Hold until the output register is free
          if (!out_valid_q || out_ready_i) begin
            out_item_q  <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ----- rtl/ira_chk.sv -----
// ---------------------------------------------------------------------------
// INDI rate controller port checker
// Watches the item channels of the top level and is bound to it.
// ---------------------------------------------------------------------------
`include "indi_rate_controller_defines.svh"

module ira_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input ira_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input ira_pkg::out_item_t out_item_o
);
  import ira_pkg::*;

  // A stalled result item holds
  `IRA_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o), "result item changed while stalled")

  // A seeding result carries a zero command
  `IRA_ASSERT_NOW(a_seed_zero, out_valid_o && out_item_o.seeded, out_item_o.command == '0, "seeded result with nonzero command")

  // An accepted update keeps the block busy for the next cycle
  `IRA_ASSERT_NEXT(a_update_busy, in_valid_i && in_ready_o && in_item_i.req_type == REQ_UPDATE, !in_ready_o, "ready right after an update item")

endmodule

bind indi_rate_controller ira_chk u_ira_chk (.*);

// ----- sim/tb.sv -----
// ---------------------------------------------------------------------------
// INDI rate controller testbench
// Drives update, set-applied, clear and unused items under random stalls, predicts
// every command in Q16.16 and compares it with the block's result items.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import ira_pkg::*;

  localparam int N_RANDOM = 1600;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  fx_t cfg_wdata_i;
  logic in_valid_i;
  logic in_ready_o;
  in_item_t in_item_i;
  logic out_valid_o;
  logic out_ready_i;
  out_item_t out_item_o;

  indi_rate_controller uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_item_o(out_item_o)
  );

  // Predictor state and register copies
  longint eff_q, gain_q, tau_q, lo_q, hi_q;
  longint gyro_q, accel_q, cmd_q;
  bit started_q;
  out_item_t cmd_expected[$];
  int errors;
  bit idle_en;
  bit out_ready_nxt;

  localparam longint LMAX = 64'sd2147483647;
  localparam longint LMIN = -64'sd2147483648;
  localparam longint ONE = 64'sd65536;
  localparam longint HALF = 64'sd32768;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic longint clip(longint x);
    if (x > LMAX) return LMAX;
    if (x < LMIN) return LMIN;
    return x;
  endfunction

  // Product with round half up, arithmetic shift is floor
  function automatic longint qmul(longint a, longint b);
    return clip((a * b + HALF) >>> 16);
  endfunction

  // Quotient rounded half away from zero
  function automatic longint qdiv(longint a, longint d);
    longint n, un, ud, q;
    bit neg;
    n = a * ONE;
    un = n < 0 ? -n : n;
    ud = d < 0 ? -d : d;
    q = (un + ud / 2) / ud;
    neg = (n < 0) != (d < 0);
    if (q > LMAX) return neg ? LMIN : LMAX;
    return neg ? -q : q;
  endfunction

  task automatic predict_reset();
    eff_q = ONE; gain_q = 0; tau_q = 0; lo_q = -ONE; hi_q = ONE;
    gyro_q = 0; accel_q = 0; cmd_q = 0; started_q = 0;
  endtask

  // Advance predictor by one accepted item; queue a command when produced
  task automatic predict_command(in_item_t it);
    longint sp, meas, dt, ap, rc, alpha, b, lo, hi, prev, acc, des, u, t;
    out_item_t r;
    sp = it.rate_setpoint; meas = it.rate_measured;
    dt = it.time_step; ap = it.applied_command;
    rc = tau_q > 0 ? tau_q : 0;
    if (it.req_type == REQ_CLEAR) begin
      gyro_q = 0; accel_q = 0; cmd_q = 0; started_q = 0;
    end else if (it.req_type == REQ_SET) begin
      cmd_q = clip(cmd_q + qmul(rc > 0 ? HALF : ONE, clip(ap - cmd_q)));
    end else if (it.req_type == REQ_UPDATE) begin
      if (!started_q || dt <= 0) begin
        gyro_q = meas; accel_q = 0; started_q = 1;
        r.command = '0; r.seeded = 1'b1;
      end else begin
        alpha = rc > 0 ? qdiv(dt, dt + rc) : ONE;
        b = eff_q != 0 ? eff_q : 1;
        lo = lo_q; hi = hi_q;
        if (lo > hi) begin
          t = lo; lo = hi; hi = t;
        end
        prev = gyro_q;
        gyro_q = clip(gyro_q + qmul(alpha, clip(meas - gyro_q)));
        acc = qdiv(clip(gyro_q - prev), dt);
        accel_q = clip(accel_q + qmul(alpha, clip(acc - accel_q)));
        des = qmul(gain_q, clip(sp - meas));
        u = clip(cmd_q + qdiv(clip(des - accel_q), b));
        if (u < lo) u = lo;
        if (u > hi) u = hi;
        cmd_q = clip(cmd_q + qmul(alpha, clip(u - cmd_q)));
        r.command = fx_t'(u); r.seeded = 1'b0;
      end
      cmd_expected.push_back(r);
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // Check result items at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cmd_expected.size() == 0) begin
        report_mismatch("unexpected item", out_item_o.command, 0);
      end else begin
        if (out_item_o.command !== cmd_expected[0].command)
          report_mismatch("command", out_item_o.command, cmd_expected[0].command);
        if (out_item_o.seeded !== cmd_expected[0].seeded)
          report_mismatch("seeded", out_item_o.seeded, cmd_expected[0].seeded);
        void'(cmd_expected.pop_front());
      end
    end
  end

  // Random receiver stalls
  always @(negedge clk_i) begin
    out_ready_nxt = idle_en ? ($urandom_range(99) >= 34) : 1'b1;
    out_ready_i <= out_ready_nxt;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, fx_t val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_EFF:  eff_q = val;
      CFG_GAIN: gain_q = val;
      CFG_TAU:  tau_q = val;
      CFG_LO:   lo_q = val;
      CFG_HI:   hi_q = val;
      default: ;
    endcase
  endtask

  // Wait for all results, then for the block to finish any silent item
  task automatic drain();
    while (cmd_expected.size() != 0) @(negedge clk_i);
    repeat (250) @(negedge clk_i);
  endtask

  task automatic send_item(in_item_t it);
    @(negedge clk_i);
    while (idle_en && $urandom_range(99) < 34) @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_command(it);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  function automatic fx_t rnd_fx();
    case ($urandom_range(5))
      0: return fx_t'($urandom());
      1: return FX_MAX;
      2: return FX_MIN;
      default: return fx_t'($signed($urandom_range(262144)) - 131072);
    endcase
  endfunction

  function automatic in_item_t rnd_item();
    in_item_t it;
    int p;
    p = $urandom_range(99);
    it.req_type = p < 75 ? REQ_UPDATE : p < 88 ? REQ_SET : p < 96 ? REQ_CLEAR : REQ_UNUSED;
    it.rate_setpoint = rnd_fx();
    it.rate_measured = rnd_fx();
    it.time_step = ($urandom_range(9) == 0) ? rnd_fx()
                 : fx_t'($urandom_range(6553, 1));
    it.applied_command = rnd_fx();
    return it;
  endfunction

  typedef struct {
    in_item_t it;
    bit has_want;
    out_item_t want;
  } dir_row_t;

  dir_row_t dir_rows[$];
  dir_row_t row;
  in_item_t ri;
  bit [2:0] phase;

  function automatic dir_row_t mk(logic [1:0] rq, fx_t sp, fx_t ms, fx_t dt, fx_t ap,
                                  bit hw, fx_t c, logic s);
    dir_row_t d;
    d.it = '{rq, sp, ms, dt, ap};
    d.has_want = hw;
    d.want = '{c, s};
    return d;
  endfunction

  initial begin
    errors = 0; idle_en = 0;
    rst_ni = 1'b0; cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_wdata_i = '0;
    in_valid_i = 1'b0; in_item_i = '0; out_ready_i = 1'b1;
    predict_reset();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table: seeding after reset, extremes, every request code
    dir_rows.push_back(mk(REQ_UPDATE, FX_MAX, FX_MIN, 32'sd655, 0, 1, 0, 1));
    dir_rows.push_back(mk(REQ_UPDATE, FX_MAX, FX_MIN, 32'sd655, 0, 0, 0, 0));
    dir_rows.push_back(mk(REQ_UPDATE, FX_MIN, FX_MAX, 32'sd655, 0, 0, 0, 0));
    dir_rows.push_back(mk(REQ_UPDATE, 0, 0, 0, 0, 1, 0, 1));
    dir_rows.push_back(mk(REQ_UPDATE, 0, 0, FX_MIN, 0, 1, 0, 1));
    dir_rows.push_back(mk(REQ_UPDATE, 0, FX_MAX, FX_MAX, 0, 0, 0, 0));
    dir_rows.push_back(mk(REQ_SET, 0, 0, 0, FX_MAX, 0, 0, 0));
    dir_rows.push_back(mk(REQ_UPDATE, 0, FX_MAX, 32'sd1, 0, 0, 0, 0));
    dir_rows.push_back(mk(REQ_SET, 0, 0, 0, FX_MIN, 0, 0, 0));
    dir_rows.push_back(mk(REQ_UNUSED, FX_MAX, FX_MAX, FX_MAX, FX_MAX, 0, 0, 0));
    dir_rows.push_back(mk(REQ_UPDATE, 32'sd65536, 0, 32'sd6553, 0, 0, 0, 0));
    dir_rows.push_back(mk(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(REQ_UPDATE, 0, 32'sd1000, 32'sd6553, 0, 1, 0, 1));
    dir_rows.push_back(mk(REQ_UPDATE, -32'sd1, 32'sd9000, 32'sd6553, 0, 0, 0, 0));

    for (int pass = 0; pass < 2; pass++) begin
      // Second pass: zero b, large gain, filtering, swapped limits
      if (pass == 1) begin
        drain();
        write_reg(CFG_EFF, 0);
        write_reg(CFG_GAIN, FX_MAX);
        write_reg(CFG_TAU, 32'sd3276);
        write_reg(CFG_LO, FX_MAX);
        write_reg(CFG_HI, FX_MIN);
      end
      foreach (dir_rows[i]) begin
        row = dir_rows[i];
        send_item(row.it);
        if (pass == 0 && row.has_want && cmd_expected.size() != 0)
          cmd_expected[$] = row.want;
      end
    end

    // Random phases, each with its own register setting
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      phase = ph[2:0];
      write_reg(CFG_EFF, phase == 0 ? FX_MIN : phase == 1 ? 32'sd1 :
                (phase == 2 ? 0 : fx_t'($signed($urandom_range(262144)) - 131072)));
      write_reg(CFG_GAIN, phase == 3 ? FX_MIN : phase == 4 ? FX_MAX : rnd_fx());
      write_reg(CFG_TAU, phase[0] ? fx_t'($urandom_range(65536)) :
                (phase == 2 ? FX_MIN : phase == 4 ? FX_MAX : 0));
      write_reg(CFG_LO, phase == 5 ? FX_MIN : phase == 6 ? 32'sd65536 : rnd_fx());
      write_reg(CFG_HI, phase == 5 ? FX_MAX : phase == 6 ? -32'sd65536 : rnd_fx());
      idle_en = (ph != 2);
      for (int n = 0; n < N_RANDOM / 8; n++) begin
        ri = rnd_item();
        send_item(ri);
        // Hold off once until every result has come
        if (ph == 4 && n == 50)
          while (cmd_expected.size() != 0) @(negedge clk_i);
      end
    end

    drain();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- indi_rate_controller.f -----
+incdir+rtl
rtl/ira_pkg.sv
rtl/ira_div.sv
rtl/indi_rate_controller.sv
rtl/ira_chk.sv
sim/tb.sv
